[hdl/qvr_pkg.sv]
// Shared constants and helpers for the quaternion view rotation unit.
`default_nettype none
package qvr_pkg;

    localparam int unsigned DefCompWidth  = 16;
    localparam int unsigned DefCordicSteps = 16;
    localparam int unsigned FieldWidth    = 16;
    localparam int unsigned AtanEntries   = 32;
    localparam int unsigned CordicWidth   = 36;
    localparam int unsigned AngleWidth    = 34;
    localparam int unsigned AccWidth      = 72;
    localparam logic signed [CordicWidth-1:0] GainQ30 = 36'sd652032874;

    typedef enum logic {
        MODE_LOAD   = 1'b0,
        MODE_ROTATE = 1'b1
    } qvr_mode_t;

    function automatic logic signed [AngleWidth-1:0] atan_entry(input logic [4:0] idx);
        logic signed [AngleWidth-1:0] val;
        case (idx)
            5'd0:  val = 34'sd536870912;
            5'd1:  val = 34'sd316933406;
            5'd2:  val = 34'sd167458907;
            5'd3:  val = 34'sd85004756;
            5'd4:  val = 34'sd42667331;
            5'd5:  val = 34'sd21354465;
            5'd6:  val = 34'sd10679838;
            5'd7:  val = 34'sd5340245;
            5'd8:  val = 34'sd2670163;
            5'd9:  val = 34'sd1335087;
            5'd10: val = 34'sd667544;
            5'd11: val = 34'sd333772;
            5'd12: val = 34'sd166886;
            5'd13: val = 34'sd83443;
            5'd14: val = 34'sd41722;
            5'd15: val = 34'sd20861;
            5'd16: val = 34'sd10430;
            5'd17: val = 34'sd5215;
            5'd18: val = 34'sd2608;
            5'd19: val = 34'sd1304;
            5'd20: val = 34'sd652;
            5'd21: val = 34'sd326;
            5'd22: val = 34'sd163;
            5'd23: val = 34'sd81;
            5'd24: val = 34'sd41;
            5'd25: val = 34'sd20;
            5'd26: val = 34'sd10;
            5'd27: val = 34'sd5;
            5'd28: val = 34'sd3;
            5'd29: val = 34'sd1;
            5'd30: val = 34'sd1;
            default: val = '0;
        endcase
        return val;
    endfunction

endpackage
`default_nettype wire

[hdl/quaternion_view_rotate_unit.sv]
// Usage:
// Top level of the quaternion view rotation unit.
// Holds a three-component view vector (Q4.12). Each request on the s_ channel
// either loads the vector (mode 0) or rotates it by the quaternion built from
// angle and axis (mode 1). Every request returns the new vector on the m_
// channel as one beat.
// Sequence: a load goes from the accept straight to the output state. A rotate
// runs CORDIC_STEPS iterations (capped at AtanEntries) of one shared add/shift
// datapath, forms the scalar part, then makes 27 passes through one shared
// multiply-accumulate unit (one product per cycle, rounding folded into the last
// pass of each component, saturation in each output's last pass) and ST_OUT.
// s_tready returns with m_tvalid, so a new request is accepted only once the one
// before it has been handed to the output register.
// s_tready is low while a request is in work, and while a finished result
// waits for the one before it to be taken on a stalled m_ side.
// Reset (aresetn low, synchronous) clears the view vector to zero and drops
// any pending result. A stalled receiver holds m_tdata steady until taken.
`default_nettype none
module quaternion_view_rotate_unit #(
    parameter int unsigned COMPONENT_WIDTH = qvr_pkg::DefCompWidth,
    parameter int unsigned CORDIC_STEPS    = qvr_pkg::DefCordicSteps
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [63:0] s_tdata,   // angle, vec_x, vec_y, vec_z
    input  wire logic        s_tuser,   // mode
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [47:0]      m_tdata    // view_x, view_y, view_z
);
    import qvr_pkg::*;

    localparam int unsigned CW = COMPONENT_WIDTH;
    localparam int unsigned NSTEP = (CORDIC_STEPS > AtanEntries) ? AtanEntries : CORDIC_STEPS;
    localparam int unsigned STW = $clog2(AtanEntries + 1);
    localparam int unsigned QW = FieldWidth + 7;
    localparam int unsigned TW = CW + 9;
    localparam int unsigned OAW = (TW > QW) ? TW : QW;
    localparam int unsigned OBW = (CW > CordicWidth) ? CW : CordicWidth;

    typedef enum logic [2:0] {
        ST_IDLE, ST_CORDIC, ST_QUAT, ST_PROD1, ST_PROD2, ST_OUT
    } state_t;

    state_t state_reg;
    logic signed [CW-1:0] view_reg [3];
    logic signed [FieldWidth-1:0] axis_reg [3];
    logic signed [CordicWidth-1:0] cx_reg, cy_reg;
    logic signed [AngleWidth-1:0] cz_reg;
    logic [STW-1:0] step_reg;
    logic signed [QW-1:0] q_reg [4];  // x, y, z, w at Q.16
    logic signed [TW-1:0] t_reg [4];  // x, y, z, w at Q.16
    logic signed [AccWidth-1:0] acc_reg;
    logic [1:0] comp_reg;
    logic [2:0] term_reg;
    logic m_tvalid_reg;
    logic [47:0] m_tdata_reg;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // shared CORDIC step: floor shifts via arithmetic shift
    logic signed [CordicWidth-1:0] dx, dy;
    logic signed [AngleWidth-1:0] at;
    assign dx = cy_reg >>> step_reg[4:0];
    assign dy = cx_reg >>> step_reg[4:0];
    assign at = atan_entry(step_reg[4:0]);

    // operand select for the one shared multiplier
    logic signed [OAW-1:0] op_a;
    logic signed [OBW-1:0] op_b;
    logic neg;
    always_comb begin
        op_a = '0;
        op_b = '0;
        neg = 1'b0;
        case (state_reg)
            ST_QUAT: begin
                op_a = OAW'(axis_reg[comp_reg]);
                op_b = OBW'(cy_reg);
            end
            ST_PROD1: begin
                // t = q*(v,0); term table per component
                case ({comp_reg, term_reg[1:0]})
                    {2'd0, 2'd0}: begin op_a = OAW'(q_reg[3]); op_b = OBW'(view_reg[0]); end
                    {2'd0, 2'd1}: begin op_a = OAW'(q_reg[1]); op_b = OBW'(view_reg[2]); end
                    {2'd0, 2'd2}: begin
                        op_a = OAW'(q_reg[2]); op_b = OBW'(view_reg[1]); neg = 1'b1;
                    end
                    {2'd1, 2'd0}: begin op_a = OAW'(q_reg[3]); op_b = OBW'(view_reg[1]); end
                    {2'd1, 2'd1}: begin
                        op_a = OAW'(q_reg[0]); op_b = OBW'(view_reg[2]); neg = 1'b1;
                    end
                    {2'd1, 2'd2}: begin op_a = OAW'(q_reg[2]); op_b = OBW'(view_reg[0]); end
                    {2'd2, 2'd0}: begin op_a = OAW'(q_reg[3]); op_b = OBW'(view_reg[2]); end
                    {2'd2, 2'd1}: begin op_a = OAW'(q_reg[0]); op_b = OBW'(view_reg[1]); end
                    {2'd2, 2'd2}: begin
                        op_a = OAW'(q_reg[1]); op_b = OBW'(view_reg[0]); neg = 1'b1;
                    end
                    {2'd3, 2'd0}: begin
                        op_a = OAW'(q_reg[0]); op_b = OBW'(view_reg[0]); neg = 1'b1;
                    end
                    {2'd3, 2'd1}: begin
                        op_a = OAW'(q_reg[1]); op_b = OBW'(view_reg[1]); neg = 1'b1;
                    end
                    {2'd3, 2'd2}: begin
                        op_a = OAW'(q_reg[2]); op_b = OBW'(view_reg[2]); neg = 1'b1;
                    end
                    default: ;
                endcase
            end
            ST_PROD2: begin
                case ({comp_reg, term_reg[1:0]})
                    {2'd0, 2'd0}: begin
                        op_a = OAW'(t_reg[3]); op_b = OBW'(q_reg[0]); neg = 1'b1;
                    end
                    {2'd0, 2'd1}: begin op_a = OAW'(t_reg[0]); op_b = OBW'(q_reg[3]); end
                    {2'd0, 2'd2}: begin
                        op_a = OAW'(t_reg[1]); op_b = OBW'(q_reg[2]); neg = 1'b1;
                    end
                    {2'd0, 2'd3}: begin op_a = OAW'(t_reg[2]); op_b = OBW'(q_reg[1]); end
                    {2'd1, 2'd0}: begin
                        op_a = OAW'(t_reg[3]); op_b = OBW'(q_reg[1]); neg = 1'b1;
                    end
                    {2'd1, 2'd1}: begin op_a = OAW'(t_reg[0]); op_b = OBW'(q_reg[2]); end
                    {2'd1, 2'd2}: begin op_a = OAW'(t_reg[1]); op_b = OBW'(q_reg[3]); end
                    {2'd1, 2'd3}: begin
                        op_a = OAW'(t_reg[2]); op_b = OBW'(q_reg[0]); neg = 1'b1;
                    end
                    {2'd2, 2'd0}: begin
                        op_a = OAW'(t_reg[3]); op_b = OBW'(q_reg[2]); neg = 1'b1;
                    end
                    {2'd2, 2'd1}: begin
                        op_a = OAW'(t_reg[0]); op_b = OBW'(q_reg[1]); neg = 1'b1;
                    end
                    {2'd2, 2'd2}: begin op_a = OAW'(t_reg[1]); op_b = OBW'(q_reg[0]); end
                    {2'd2, 2'd3}: begin op_a = OAW'(t_reg[2]); op_b = OBW'(q_reg[3]); end
                    default: ;
                endcase
            end
            default: ;
        endcase
    end

    logic signed [OAW+OBW-1:0] prod_full;
    logic signed [AccWidth-1:0] prod, acc_sum;
    assign prod_full = op_a * op_b;
    assign prod = neg ? -AccWidth'(prod_full) : AccWidth'(prod_full);
    assign acc_sum = acc_reg + prod;

    // saturate to the signed CW-bit range (round half up is applied before the call)
    function automatic logic signed [CW-1:0] sat(input logic signed [AccWidth-1:0] v);
        logic signed [AccWidth-1:0] hi, lo;
        hi = (AccWidth'(1) <<< (CW - 1)) - 1;
        lo = -hi - 1;
        if (v > hi) return hi[CW-1:0];
        if (v < lo) return lo[CW-1:0];
        return v[CW-1:0];
    endfunction

    logic signed [AccWidth-1:0] rnd_q, rnd_t, rnd_v, rnd_w;
    assign rnd_q = acc_sum + (AccWidth'(1) <<< 25);
    assign rnd_t = acc_sum + (AccWidth'(1) <<< 11);
    assign rnd_v = acc_sum + (AccWidth'(1) <<< 19);
    assign rnd_w = AccWidth'(cx_reg) + (AccWidth'(1) <<< 13);

    logic signed [AccWidth-1:0] lvx, lvy, lvz;
    assign lvx = AccWidth'($signed(s_tdata[31:16]));
    assign lvy = AccWidth'($signed(s_tdata[47:32]));
    assign lvz = AccWidth'($signed(s_tdata[63:48]));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
            for (int i = 0; i < 3; i++) view_reg[i] <= '0;
        end else begin
            case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        axis_reg[0] <= s_tdata[31:16];
                        axis_reg[1] <= s_tdata[47:32];
                        axis_reg[2] <= s_tdata[63:48];
                        cx_reg <= GainQ30;
                        cy_reg <= '0;
                        cz_reg <= AngleWidth'($signed(s_tdata[15:0])) <<< 15;
                        step_reg <= '0;
                        if (s_tuser == MODE_ROTATE) begin
                            state_reg <= ST_CORDIC;
                        end else begin
                            view_reg[0] <= sat(lvx);
                            view_reg[1] <= sat(lvy);
                            view_reg[2] <= sat(lvz);
                            state_reg <= ST_OUT;
                        end
                    end
                end
                ST_CORDIC: begin
                    if (step_reg == STW'(NSTEP)) begin
                        comp_reg <= '0;
                        acc_reg <= '0;
                        q_reg[3] <= QW'(rnd_w >>> 14);
                        state_reg <= ST_QUAT;
                    end else begin
                        if (!cz_reg[AngleWidth-1]) begin
                            cx_reg <= cx_reg - dx;
                            cy_reg <= cy_reg + dy;
                            cz_reg <= cz_reg - at;
                        end else begin
                            cx_reg <= cx_reg + dx;
                            cy_reg <= cy_reg - dy;
                            cz_reg <= cz_reg + at;
                        end
                        step_reg <= step_reg + 1'b1;
                    end
                end
                ST_QUAT: begin
                    q_reg[comp_reg] <= QW'(rnd_q >>> 26);
                    if (comp_reg == 2'd2) begin
                        comp_reg <= '0;
                        term_reg <= '0;
                        state_reg <= ST_PROD1;
                    end else begin
                        comp_reg <= comp_reg + 1'b1;
                    end
                end
                ST_PROD1: begin
                    if (term_reg == 3'd2) begin
                        t_reg[comp_reg] <= TW'(rnd_t >>> 12);
                        acc_reg <= '0;
                        term_reg <= '0;
                        comp_reg <= comp_reg + 1'b1;
                        if (comp_reg == 2'd3) state_reg <= ST_PROD2;
                    end else begin
                        acc_reg <= acc_sum;
                        term_reg <= term_reg + 1'b1;
                    end
                end
                ST_PROD2: begin
                    if (term_reg == 3'd3) begin
                        view_reg[comp_reg] <= sat(rnd_v >>> 20);
                        acc_reg <= '0;
                        term_reg <= '0;
                        if (comp_reg == 2'd2) state_reg <= ST_OUT;
                        else comp_reg <= comp_reg + 1'b1;
                    end else begin
                        acc_reg <= acc_sum;
                        term_reg <= term_reg + 1'b1;
                    end
                end
                ST_OUT: begin
                    // hold the result until the previous one is taken
                    if (!m_tvalid_reg || m_tready) begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg <= {16'(view_reg[2]), 16'(view_reg[1]), 16'(view_reg[0])};
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
            if (m_tvalid_reg && m_tready && state_reg != ST_OUT) m_tvalid_reg <= 1'b0;
        end
    end

endmodule
`default_nettype wire

[hdl/qvr_checker.sv]
// Port-level checker for the quaternion view rotation unit, with its bind.
`default_nettype none
module qvr_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [47:0] m_tdata
);
    // one request in flight: no accept right after an accept
    a_no_back: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready) else $error("accept while busy");
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)) else $error("result dropped");
    a_rst: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && s_tready) else $error("reset state");
    // a new result only follows an accepted request
    a_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(!s_tready)) else $error("result without request");
endmodule

bind quaternion_view_rotate_unit qvr_checker u_qvr_checker (
    .aclk(aclk), .aresetn(aresetn), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);
`default_nettype wire
